/* src/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
package deq_pkg;

	// Ring storage depth and the widths that follow from it.
	localparam int unsigned DEPTH = 16;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned OUT_BITS = 2 * DATA_W + CNT_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// Command codes carried in the request tuser field.
	typedef enum logic [CMD_W-1:0] {
		CMD_NONE     = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_REM_HEAD = 3'd3,
		CMD_REM_TAIL = 3'd4,
		CMD_CLEAR    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic exec;
		logic load;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

/* src/deq_ctrl.sv */
// Sequencing state machine for the double-ended queue.
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  deq_pkg::dp_status_t status,
	output deq_pkg::dp_cmd_t    cmd
);

	deq_pkg::state_t state_q;
	deq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready = 1'b0;
		cmd = '0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_nxt = deq_pkg::ST_READ;
				end
			end
			deq_pkg::ST_READ: begin
				state_nxt = deq_pkg::ST_LOAD;
			end
			deq_pkg::ST_LOAD: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_nxt = deq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = deq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* src/deq_dp.sv */
// Ring storage, head and count registers and result register of the queue.
module deq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::dp_cmd_t    cmd,
	output deq_pkg::dp_status_t status,
	input  logic [deq_pkg::CMD_W-1:0] command,
	input  deq_pkg::data_t      item_value,
	output logic                out_valid,
	input  logic                out_ready,
	output deq_pkg::data_t      head_value,
	output deq_pkg::data_t      tail_value,
	output deq_pkg::cnt_t       item_count,
	output logic                overflow
);

	localparam deq_pkg::cnt_t DEPTH_C = deq_pkg::CNT_W'(deq_pkg::DEPTH);
	localparam deq_pkg::idx_t LAST_IDX = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);
	localparam int unsigned SUM_W = deq_pkg::CNT_W + 1;

	// Adds an offset below DEPTH to a ring index; one compare and subtract wraps it.
	function automatic deq_pkg::idx_t ring_add(deq_pkg::idx_t base, deq_pkg::cnt_t offs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offs);
		if (sum >= SUM_W'(deq_pkg::DEPTH)) begin
			sum = sum - SUM_W'(deq_pkg::DEPTH);
		end
		return sum[deq_pkg::IDX_W-1:0];
	endfunction

	deq_pkg::data_t mem [deq_pkg::DEPTH];

	deq_pkg::idx_t head_q;
	deq_pkg::cnt_t count_q;
	logic          ovf_q;
	deq_pkg::data_t rd_head_q;
	deq_pkg::data_t rd_tail_q;

	logic           out_valid_q;
	deq_pkg::data_t out_head_q;
	deq_pkg::data_t out_tail_q;
	deq_pkg::cnt_t  out_count_q;
	logic           out_ovf_q;

	deq_pkg::idx_t head_nxt;
	deq_pkg::cnt_t count_nxt;
	logic          ovf_nxt;
	logic          wr_en;
	deq_pkg::idx_t wr_idx;
	deq_pkg::idx_t head_dec;
	deq_pkg::idx_t head_inc;
	deq_pkg::idx_t tail_rd_idx;
	logic          full;
	logic          empty;

	assign full = (count_q >= DEPTH_C);
	assign empty = (count_q == '0);
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - deq_pkg::IDX_W'(1);
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + deq_pkg::IDX_W'(1);
	assign tail_rd_idx = empty ? head_q : ring_add(head_q, count_q - deq_pkg::CNT_W'(1));

	always_comb begin
		head_nxt = head_q;
		count_nxt = count_q;
		ovf_nxt = 1'b0;
		wr_en = 1'b0;
		wr_idx = head_dec;
		case (deq_pkg::cmd_t'(command))
			deq_pkg::CMD_INS_HEAD: begin
				if (full) begin
					ovf_nxt = 1'b1;
				end else begin
					head_nxt = head_dec;
					wr_en = 1'b1;
					wr_idx = head_dec;
					count_nxt = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::CMD_INS_TAIL: begin
				if (full) begin
					ovf_nxt = 1'b1;
				end else begin
					wr_en = 1'b1;
					wr_idx = ring_add(head_q, count_q);
					count_nxt = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::CMD_REM_HEAD: begin
				if (!empty) begin
					head_nxt = head_inc;
					count_nxt = count_q - deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::CMD_REM_TAIL: begin
				if (!empty) begin
					count_nxt = count_q - deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::CMD_CLEAR: begin
				head_nxt = '0;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.exec) begin
			head_q <= head_nxt;
			count_q <= count_nxt;
			ovf_q <= ovf_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_idx] <= item_value;
		end
	end

	// Both ends are read every cycle; the values settle in the cycle after an update.
	always_ff @(posedge clk) begin
		rd_head_q <= mem[head_q];
		rd_tail_q <= mem[tail_rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_head_q <= empty ? '0 : rd_head_q;
			out_tail_q <= empty ? '0 : rd_tail_q;
			out_count_q <= count_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign head_value = out_head_q;
	assign tail_value = out_tail_q;
	assign item_count = out_count_q;
	assign overflow = out_ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stored count exceeds the ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_IDX)
		else $error("head index outside the ring");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (command == deq_pkg::CMD_CLEAR) |=> (count_q == '0) && (head_q == '0))
		else $error("clear did not empty the queue");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && full && ((command == deq_pkg::CMD_INS_HEAD) ||
		(command == deq_pkg::CMD_INS_TAIL)) |=> ovf_q && $stable(count_q) && $stable(head_q))
		else $error("insert into a full queue changed state or missed overflow");
`endif

endmodule

/* src/double_ended_queue.sv */
// Top level of the bounded double-ended queue of signed 32-bit values.
// Requests are taken one at a time: accept, read both ring ends, load the result.
// The load waits for a free result register, then the result shows on m_tvalid.
// The result register lets a new request enter while the previous result waits.
// arst_n clears the queue (head index and count to zero) and the result valid flag.
// Ring contents are not cleared; only occupied slots are ever shown.
module double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] item_value
	input  logic [2:0]  s_tuser,  // [2:0] command
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata, // [31:0] head_value, [63:32] tail_value,
	                                                 // [68:64] item_count, rest zero
	output logic [0:0]  m_tuser   // [0] overflow
);

	deq_pkg::dp_cmd_t    cmd;
	deq_pkg::dp_status_t status;
	deq_pkg::data_t      head_value;
	deq_pkg::data_t      tail_value;
	deq_pkg::cnt_t       item_count;
	logic                overflow;

	// The controller sequences each request through the datapath.
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the ring, its head index and count, and the result register.
	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.command    (s_tuser),
		.item_value (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.head_value (head_value),
		.tail_value (tail_value),
		.item_count (item_count),
		.overflow   (overflow)
	);

	// Fields are packed from the lowest bit up, padded with zeros to whole bytes.
	assign m_tdata = deq_pkg::OUT_TDATA_W'({item_count, tail_value, head_value});
	assign m_tuser = overflow;

endmodule
